>>> rtl/wst_pkg.sv
package wst_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP   = 8'd0,
    REG_SAMPLE_COUNT = 8'd1,
    REG_STEREO       = 8'd2,
    REG_SMP_RATE     = 8'd3
  } cfg_reg_t;

  // byte source of an item in flight
  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_RAM,
    SRC_LO,
    SRC_HI
  } src_t;

  localparam logic [31:0] RST_PHASE_STEP   = 32'd42852282;
  localparam logic [23:0] RST_SAMPLE_COUNT = 24'd88200;
  localparam logic        RST_STEREO       = 1'b0;
  localparam logic [17:0] RST_SMP_RATE     = 18'd44100;

  localparam logic [5:0]  HDR_LEN       = 6'd44;
  localparam int          HDR_BITS      = 352;
  localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
  localparam logic [31:0] RIFF_BASE     = 32'd36;
  localparam logic [31:0] FMT_LEN       = 32'd16;
  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [15:0] BITS_PER_SMP  = 16'd16;

  localparam logic [63:0] HALF_PI_Q61   = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] SINE_AMPL     = 64'd32767;
  localparam int          TAYLOR_TERMS  = 24;
  localparam logic [11:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    12'd6,    12'd20,   12'd42,   12'd72,   12'd110,  12'd156,
    12'd210,  12'd272,  12'd342,  12'd420,  12'd506,  12'd600,
    12'd702,  12'd812,  12'd930,  12'd1056, 12'd1190, 12'd1332,
    12'd1482, 12'd1640, 12'd1806, 12'd1980, 12'd2162, 12'd2352
  };

  function automatic logic [63:0] mul_q61(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[124:61];
  endfunction

  // rint(32767 * sin(x)) for x in [0, pi/2], x in Q61
  function automatic logic [15:0] quarter_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] r;
    x2 = mul_q61(x, x);
    t  = x;
    s  = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      if (t != 64'd0) begin
        t = mul_q61(t, x2) / TAYLOR_DIV[n-1];
        if ((n & 1) != 0) s = s - t;
        else              s = s + t;
      end
    end
    v = (((s >> 32) * SINE_AMPL) << 3) + (((s & 64'hFFFF_FFFF) * SINE_AMPL) >> 29);
    r = (v + 64'h8000_0000) >> 32;
    return (r > SINE_AMPL) ? 16'd32767 : r[15:0];
  endfunction

endpackage

>>> rtl/wst_ram.sv
module wst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wav_sine_tone_byte_source.sv
// Streams a complete 16-bit PCM WAV file, one byte per accepted in_tdata beat: the 44-byte
// RIFF/WAVE header, then the tone samples little-endian, each written once (mono) or twice
// (stereo); out_tlast marks the final byte and the next beat starts an identical new file.
// Setting bit 0 of in_tdata restarts at header byte zero. After reset the sine ROM is
// copied into the table RAM, one entry a cycle, so in_tready stays low until the last entry
// has been written; cfg writes are taken at any time but must only be issued while no
// beats are in flight. Then one beat is accepted every cycle unless the output is stalled
// by out_tready: the input stage updates positions and phase and issues the table RAM
// read, whose registered output is covered by a second stage, and each byte is then
// registered onto out_tdata.
module wav_sine_tone_byte_source #(
  parameter int TABLE_BITS = 10,
  parameter int PHASE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] file_byte
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import wst_pkg::*;

  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int QUARTER    = TABLE_SIZE / 4;

  typedef logic [15:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t                  rom;
    logic [15:0]           q [QUARTER+1];
    logic [63:0]           x_step;
    logic [TABLE_BITS-1:0] idx;
    logic [15:0]           m;
    int                    r;
    x_step = HALF_PI_Q61 >> (TABLE_BITS - 2);
    for (int i = 0; i <= QUARTER; i++) begin
      q[i] = quarter_sine(x_step * 64'(i));
    end
    for (int i = 0; i < TABLE_SIZE; i++) begin
      idx    = TABLE_BITS'(i);
      r      = int'(idx[TABLE_BITS-3:0]);
      m      = idx[TABLE_BITS-2] ? q[QUARTER - r] : q[r];
      rom[i] = idx[TABLE_BITS-1] ? (16'd0 - m) : m;
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration
  logic [31:0] phase_step_r;
  logic [23:0] sample_count_r;
  logic        stereo_r;
  logic [17:0] smp_rate_r;

  // table fill
  logic                  fill_busy_r;
  logic [TABLE_BITS-1:0] fill_cnt_r;
  logic                  fill_wr_r;
  logic [TABLE_BITS-1:0] fill_waddr_r;
  logic [15:0]           fill_wdata_r;

  // file position
  logic [5:0]            hdr_pos_r;
  logic [23:0]           frame_idx_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [1:0]            bif_r;

  logic [5:0]            hdr_pos_cur, hdr_pos_nxt;
  logic [23:0]           frame_idx_cur, frame_idx_nxt;
  logic [PHASE_BITS-1:0] phase_cur, phase_nxt;
  logic [1:0]            bif_cur, bif_nxt, bif_inc;
  logic                  clr;
  logic                  eof;
  logic                  rd_en;
  src_t                  src;
  logic [7:0]            hdr_byte;

  // header image
  logic [31:0]         data_size;
  logic [15:0]         channels;
  logic [31:0]         byte_rate;
  logic [HDR_BITS-1:0] hdr_vec;

  // pipeline
  logic        in_accept;
  logic        mid_adv;
  logic        mid_valid_r;
  src_t        mid_src_r;
  logic [7:0]  mid_hdr_r;
  logic        mid_eof_r;
  logic [15:0] cur_sample_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic [7:0]  mid_byte;
  logic [15:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= RST_PHASE_STEP;
      sample_count_r <= RST_SAMPLE_COUNT;
      stereo_r       <= RST_STEREO;
      smp_rate_r     <= RST_SMP_RATE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:   phase_step_r   <= cfg_data;
        REG_SAMPLE_COUNT: sample_count_r <= cfg_data[23:0];
        REG_STEREO:       stereo_r       <= cfg_data[0];
        REG_SMP_RATE:     smp_rate_r     <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // copy the ROM into the table RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
      fill_wr_r   <= 1'b0;
    end else begin
      fill_wr_r <= fill_busy_r;
      if (fill_busy_r) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
        if (fill_cnt_r == {TABLE_BITS{1'b1}}) begin
          fill_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_waddr_r <= fill_cnt_r;
    fill_wdata_r <= SINE_ROM[fill_cnt_r];
  end

  assign data_size = {6'd0, sample_count_r, 2'b00} >> (stereo_r ? 0 : 1);
  assign channels  = stereo_r ? 16'd2 : 16'd1;
  assign byte_rate = {12'd0, smp_rate_r, 2'b00} >> (stereo_r ? 0 : 1);
  assign hdr_vec   = {data_size, TAG_DATA, BITS_PER_SMP, channels << 1, byte_rate,
                      {14'd0, smp_rate_r}, channels, FMT_PCM, FMT_LEN, TAG_FMT,
                      TAG_WAVE, RIFF_BASE + data_size, TAG_RIFF};

  assign mid_adv   = mid_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !fill_busy_r && !fill_wr_r && (!mid_valid_r || !out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    clr = in_tdata[0] || (hdr_pos_r >= HDR_LEN && frame_idx_r >= sample_count_r);
    hdr_pos_cur   = clr ? '0 : hdr_pos_r;
    frame_idx_cur = clr ? '0 : frame_idx_r;
    phase_cur     = clr ? '0 : phase_r;
    bif_cur       = clr ? '0 : bif_r;

    hdr_pos_nxt   = hdr_pos_cur;
    frame_idx_nxt = frame_idx_cur;
    phase_nxt     = phase_cur;
    bif_nxt       = bif_cur;
    bif_inc       = bif_cur + 2'd1;
    eof           = 1'b0;
    rd_en         = 1'b0;
    src           = SRC_HDR;
    hdr_byte      = hdr_vec[{hdr_pos_cur, 3'b000} +: 8];

    if (hdr_pos_cur < HDR_LEN) begin
      hdr_pos_nxt = hdr_pos_cur + 6'd1;
      eof         = (hdr_pos_nxt == HDR_LEN) && (sample_count_r == '0);
    end else begin
      if (bif_cur == 2'd0) begin
        rd_en     = 1'b1;
        phase_nxt = phase_cur + PHASE_BITS'(phase_step_r);
        src       = SRC_RAM;
      end else if (bif_cur[0]) begin
        src = SRC_HI;
      end else begin
        src = SRC_LO;
      end
      if (bif_inc == 2'd0 || (!stereo_r && bif_inc >= 2'd2)) begin
        bif_nxt       = 2'd0;
        frame_idx_nxt = frame_idx_cur + 24'd1;
        eof           = frame_idx_nxt >= sample_count_r;
      end else begin
        bif_nxt = bif_inc;
      end
    end

    if (eof) begin
      hdr_pos_nxt   = '0;
      frame_idx_nxt = '0;
      phase_nxt     = '0;
      bif_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= '0;
      frame_idx_r <= '0;
      phase_r     <= '0;
      bif_r       <= '0;
    end else if (in_accept) begin
      hdr_pos_r   <= hdr_pos_nxt;
      frame_idx_r <= frame_idx_nxt;
      phase_r     <= phase_nxt;
      bif_r       <= bif_nxt;
    end
  end

  wst_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (fill_wr_r),
    .waddr (fill_waddr_r),
    .wdata (fill_wdata_r),
    .re    (in_accept && rd_en),
    .raddr (phase_cur[PHASE_BITS-1 -: TABLE_BITS]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (in_accept) begin
      mid_valid_r <= 1'b1;
    end else if (mid_adv) begin
      mid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mid_src_r <= src;
      mid_hdr_r <= hdr_byte;
      mid_eof_r <= eof;
    end
    if (mid_adv && mid_src_r == SRC_RAM) begin
      cur_sample_r <= ram_rdata;
    end
  end

  always_comb begin
    case (mid_src_r)
      SRC_HDR: mid_byte = mid_hdr_r;
      SRC_RAM: mid_byte = ram_rdata[7:0];
      SRC_LO:  mid_byte = cur_sample_r[7:0];
      SRC_HI:  mid_byte = cur_sample_r[15:8];
      default: mid_byte = mid_hdr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv) begin
      out_data_r <= mid_byte;
      out_last_r <= mid_eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
